### src/icdo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package icdo_pkg;

  localparam int FIELD_W = 32;
  localparam int CHAR_W  = 8;
  localparam int STAT_W  = 2;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [3:0]        CH_DIGIT_HI = 4'h3;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_DIV0 = 2'd1;
  localparam logic [STAT_W-1:0] ST_MOD0 = 2'd2;

endpackage

`default_nettype wire

### src/int_calculator_decimal_out.sv
`timescale 1ns / 1ps
`default_nettype none

// Signed integer calculator with decimal ASCII output. One request is taken
// per in_valid/in_stall transfer; the block then streams the result as ASCII
// characters (optional '-', digits most significant first, newline with
// last=1) over out_valid/out_stall. A divide or modulo by zero gives a single
// transfer with status set and last=1. Operands are sign-extended or
// truncated to DATA_WIDTH and all arithmetic wraps at DATA_WIDTH. Requests are
// handled one at a time. Multiply (shift-add) and divide (restoring) each
// work one operand bit per cycle, and divide then fixes the result's sign;
// binary to decimal conversion then takes one bit per cycle; leading zeros
// are then suppressed, and the characters follow, held while the output is
// stalled. The input stays stalled from the accepted request until its
// newline or error transfer is loaded into the output register.
module int_calculator_decimal_out
  import icdo_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [FIELD_W-1:0] operand_a,
  input  wire logic signed [FIELD_W-1:0] operand_b,
  input  wire logic [CHAR_W-1:0]        req_type,
  input  wire logic                     op_single,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [CHAR_W-1:0]             out_char,
  output logic [STAT_W-1:0]             status,
  output logic                          last
);

  localparam int W  = DATA_WIDTH;
  localparam int ND = (DATA_WIDTH * 30103) / 100000 + 1;
  localparam int CW = $clog2(DATA_WIDTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_DFIX  = 4'd3;
  localparam logic [3:0] S_MAG   = 4'd4;
  localparam logic [3:0] S_CONV  = 4'd5;
  localparam logic [3:0] S_TRIM  = 4'd6;
  localparam logic [3:0] S_SIGN  = 4'd7;
  localparam logic [3:0] S_DIGIT = 4'd8;
  localparam logic [3:0] S_NL    = 4'd9;
  localparam logic [3:0] S_ERR   = 4'd10;

  logic [3:0]        state;
  logic [W-1:0]      opa;
  logic [W-1:0]      opb;
  logic [W-1:0]      rem;
  logic [W-1:0]      res;
  logic [4*ND-1:0]   bcd;
  logic [CW-1:0]     cnt;
  logic              op_mod;
  logic              a_neg;
  logic              b_neg;
  logic              neg;
  logic [STAT_W-1:0] err_code;

  logic [63:0]       a_ext;
  logic [63:0]       b_ext;
  logic [W-1:0]      a_w;
  logic [W-1:0]      b_w;
  logic              accept;
  logic              known_op;
  logic              out_ready;
  logic              out_load;
  logic [CHAR_W-1:0] out_char_next;
  logic [STAT_W-1:0] status_next;
  logic              last_next;
  logic [W:0]        trial;
  logic              trial_ok;
  logic [4*ND-1:0]   bcd_adj;
  logic [3:0]        top_digit;

  assign a_ext = {{(64 - FIELD_W){operand_a[FIELD_W-1]}}, operand_a};
  assign b_ext = {{(64 - FIELD_W){operand_b[FIELD_W-1]}}, operand_b};
  assign a_w   = a_ext[W-1:0];
  assign b_w   = b_ext[W-1:0];

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign known_op  = op_single && (req_type == CH_PLUS || req_type == CH_MINUS ||
                     req_type == CH_STAR || req_type == CH_SLASH || req_type == CH_PCT);
  assign out_ready = !out_valid || !out_stall;

  assign trial    = {rem, opa[W-1]};
  assign trial_ok = (trial >= {1'b0, opb});

  assign top_digit = bcd[4*ND-1 -: 4];

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_comb begin
    out_load      = 1'b0;
    out_char_next = CH_NUL;
    status_next   = ST_OK;
    last_next     = 1'b0;
    case (state)
      S_SIGN: begin
        out_load      = out_ready;
        out_char_next = CH_MINUS;
      end
      S_DIGIT: begin
        out_load      = out_ready;
        out_char_next = {CH_DIGIT_HI, top_digit};
      end
      S_NL: begin
        out_load      = out_ready;
        out_char_next = CH_NL;
        last_next     = 1'b1;
      end
      S_ERR: begin
        out_load      = out_ready;
        status_next   = err_code;
        last_next     = 1'b1;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char <= out_char_next;
      status   <= status_next;
      last     <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            cnt    <= '0;
            op_mod <= (req_type == CH_PCT);
            a_neg  <= a_w[W-1];
            b_neg  <= b_w[W-1];
            if (!known_op) begin
              res   <= '0;
              state <= S_MAG;
            end else if (req_type == CH_PLUS) begin
              res   <= a_w + b_w;
              state <= S_MAG;
            end else if (req_type == CH_MINUS) begin
              res   <= a_w - b_w;
              state <= S_MAG;
            end else if (req_type == CH_STAR) begin
              res   <= '0;
              opa   <= a_w;
              opb   <= b_w;
              state <= S_MUL;
            end else if (b_w == '0) begin
              err_code <= (req_type == CH_PCT) ? ST_MOD0 : ST_DIV0;
              state    <= S_ERR;
            end else begin
              opa   <= a_w[W-1] ? (~a_w + 1'b1) : a_w;
              opb   <= b_w[W-1] ? (~b_w + 1'b1) : b_w;
              rem   <= '0;
              state <= S_DIV;
            end
          end
        end
        S_MUL: begin
          if (opb[0]) begin
            res <= res + opa;
          end
          opa <= {opa[W-2:0], 1'b0};
          opb <= {1'b0, opb[W-1:1]};
          cnt <= cnt + 1'b1;
          if (cnt == CW'(W - 1)) begin
            state <= S_MAG;
          end
        end
        S_DIV: begin
          rem <= trial_ok ? W'(trial - {1'b0, opb}) : trial[W-1:0];
          opa <= {opa[W-2:0], trial_ok};
          cnt <= cnt + 1'b1;
          if (cnt == CW'(W - 1)) begin
            state <= S_DFIX;
          end
        end
        S_DFIX: begin
          if (op_mod) begin
            res <= a_neg ? (~rem + 1'b1) : rem;
          end else begin
            res <= (a_neg ^ b_neg) ? (~opa + 1'b1) : opa;
          end
          state <= S_MAG;
        end
        S_MAG: begin
          neg   <= res[W-1];
          opa   <= res[W-1] ? (~res + 1'b1) : res;
          bcd   <= '0;
          cnt   <= '0;
          state <= S_CONV;
        end
        S_CONV: begin
          bcd <= {bcd_adj[4*ND-2:0], opa[W-1]};
          opa <= {opa[W-2:0], 1'b0};
          if (cnt == CW'(W - 1)) begin
            cnt   <= CW'(ND);
            state <= S_TRIM;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_TRIM: begin
          if (top_digit == 4'd0 && cnt != CW'(1)) begin
            bcd <= {bcd[4*ND-5:0], 4'd0};
            cnt <= cnt - 1'b1;
          end else begin
            state <= neg ? S_SIGN : S_DIGIT;
          end
        end
        S_SIGN: begin
          if (out_ready) begin
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (out_ready) begin
            bcd <= {bcd[4*ND-5:0], 4'd0};
            cnt <= cnt - 1'b1;
            if (cnt == CW'(1)) begin
              state <= S_NL;
            end
          end
        end
        S_NL: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        S_ERR: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
